[design/ihrl_pkg.sv]
// Shared types and constants for the Intel HEX record loader.
package ihrl_pkg;

    localparam int BYTE_W = 8;
    localparam int ADDR_W = 16;
    localparam int KIND_W = 3;

    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UF    = 8'h46;
    localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
    localparam logic [BYTE_W-1:0] HEX_TEN  = 8'd10;

    localparam logic [BYTE_W-1:0] REC_DATA = 8'h00;
    localparam logic [BYTE_W-1:0] REC_EOF  = 8'h01;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE    = 3'd0,
        KIND_EOF      = 3'd1,
        KIND_LEN_ERR  = 3'd2,
        KIND_CSUM_ERR = 3'd3,
        KIND_TYPE_ERR = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2,
        PH_CSUM   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        HB_LENGTH = 2'd0,
        HB_ADDR_H = 2'd1,
        HB_ADDR_L = 2'd2,
        HB_TYPE   = 2'd3
    } t_hdr_byte;

    // one queued job for the emitter
    typedef struct packed {
        t_kind               kind;
        logic [ADDR_W-1:0]   addr;
        logic [BYTE_W-1:0]   len;
    } t_cmd;

    // record buffer write from the parser
    typedef struct packed {
        logic                we;
        logic [BYTE_W-1:0]   idx;
        logic [BYTE_W-1:0]   data;
    } t_buf_wr;

endpackage

[design/intel_hex_record_loader.sv]
// Intel HEX record loader top level: parser, job queue and write emitter.
//
// Input channel: one ASCII character per beat (i_in_valid / o_in_stall).
// Output channel: one result per beat (o_out_valid / i_out_stall): a memory
// write, end of file, or a length, checksum or type error. last marks the
// final result caused by one character.
// Throughput: one character per cycle. While a record's writes are still
// being emitted, data characters of the next record are held off; one
// write leaves per cycle while the receiver does not stall. The parser
// also holds when the two-entry job queue is full.
// A single result passes the queue, read stage and output register after
// its character; the first write of a record passes the queue, burst
// start, buffer read and output register after the checksum character.
// Reset (synchronous, active low) returns the parser to waiting for a colon
// and empties the queue and output register; the record buffer is not
// cleared, each entry is written before it is read.
// When the receiver stalls, the output register holds its beat, the read
// stage and queue fill, and then o_in_stall rises.
module intel_hex_record_loader #(
    parameter int MAX_RECORD_BYTES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ihrl_pkg::BYTE_W-1:0] i_char_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ihrl_pkg::KIND_W-1:0] o_kind,
    output logic [ihrl_pkg::ADDR_W-1:0] o_write_address,
    output logic [ihrl_pkg::BYTE_W-1:0] o_write_data,
    output logic                        o_last
);

    logic              push, pop, q_empty, q_full, back_busy;
    ihrl_pkg::t_cmd    cmd, head;
    ihrl_pkg::t_buf_wr buf_wr;

    ihrl_front #(
        .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_char_in   (i_char_in),
        .i_q_full    (q_full),
        .i_back_busy (back_busy || !q_empty),
        .o_push      (push),
        .o_cmd       (cmd),
        .o_buf_wr    (buf_wr)
    );

    ihrl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    ihrl_back #(
        .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_buf_wr        (buf_wr),
        .i_head          (head),
        .i_q_empty       (q_empty),
        .o_pop           (pop),
        .o_busy          (back_busy),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_write_address (o_write_address),
        .o_write_data    (o_write_data),
        .o_last          (o_last)
    );

endmodule

[design/ihrl_front.sv]
// Character parser: decodes hex pairs, checks records, queues jobs.
module ihrl_front #(
    parameter int MAX_RECORD_BYTES = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [ihrl_pkg::BYTE_W-1:0] i_char_in,
    input  logic                      i_q_full,
    input  logic                      i_back_busy,
    output logic                      o_push,
    output ihrl_pkg::t_cmd            o_cmd,
    output ihrl_pkg::t_buf_wr         o_buf_wr
);

    localparam logic [ihrl_pkg::BYTE_W-1:0] MAX_B = ihrl_pkg::BYTE_W'(MAX_RECORD_BYTES);

    ihrl_pkg::t_phase                r_phase, n_phase;
    logic [3:0]                      r_hi, n_hi;
    logic                            r_have, n_have;
    logic [1:0]                      r_hidx, n_hidx;
    logic [ihrl_pkg::BYTE_W-1:0]     r_len, n_len;
    logic [ihrl_pkg::ADDR_W-1:0]     r_addr, n_addr;
    logic [ihrl_pkg::BYTE_W-1:0]     r_cnt, n_cnt;
    logic [ihrl_pkg::BYTE_W-1:0]     r_sum, n_sum;

    logic                            accept;
    logic [3:0]                      nib;
    logic [ihrl_pkg::BYTE_W-1:0]     byte_v;
    logic [ihrl_pkg::BYTE_W-1:0]     sum_v;
    logic [ihrl_pkg::BYTE_W-1:0]     cnt_inc;

    function automatic logic [3:0] hex_value(input logic [ihrl_pkg::BYTE_W-1:0] c);
        logic [ihrl_pkg::BYTE_W-1:0] t;
        t = 8'h00;
        if (c >= ihrl_pkg::CH_ZERO && c <= ihrl_pkg::CH_NINE) begin
            t = c - ihrl_pkg::CH_ZERO;
        end else if (c >= ihrl_pkg::CH_UA && c <= ihrl_pkg::CH_UF) begin
            t = c - ihrl_pkg::CH_UA + ihrl_pkg::HEX_TEN;
        end else begin
            t = c - ihrl_pkg::CH_LA + ihrl_pkg::HEX_TEN;
        end
        return t[3:0];
    endfunction

    assign o_in_stall = i_q_full || (r_phase == ihrl_pkg::PH_DATA && i_back_busy);
    assign accept     = i_in_valid && !o_in_stall;
    assign nib        = hex_value(i_char_in);
    assign byte_v     = {r_hi, nib};
    assign sum_v      = r_sum + byte_v;
    assign cnt_inc    = r_cnt + 8'd1;

    always_comb begin
        n_phase = r_phase;
        n_hi    = r_hi;
        n_have  = r_have;
        n_hidx  = r_hidx;
        n_len   = r_len;
        n_addr  = r_addr;
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        o_push  = 1'b0;
        o_cmd   = '{kind: ihrl_pkg::KIND_WRITE, addr: r_addr, len: r_len};
        o_buf_wr = '{we: 1'b0, idx: r_cnt, data: byte_v};

        if (accept) begin
            if (r_phase == ihrl_pkg::PH_WAIT) begin
                if (i_char_in == ihrl_pkg::CH_COLON) begin
                    n_phase = ihrl_pkg::PH_HEADER;
                    n_have  = 1'b0;
                    n_hi    = 4'd0;
                    n_hidx  = 2'd0;
                    n_cnt   = '0;
                    n_sum   = '0;
                end
            end else if (!r_have) begin
                n_hi   = nib;
                n_have = 1'b1;
            end else begin
                n_have = 1'b0;
                n_sum  = sum_v;
                case (r_phase)
                    ihrl_pkg::PH_HEADER: begin
                        case (ihrl_pkg::t_hdr_byte'(r_hidx))
                            ihrl_pkg::HB_LENGTH: begin
                                n_len  = byte_v;
                                n_hidx = r_hidx + 2'd1;
                            end
                            ihrl_pkg::HB_ADDR_H: begin
                                n_addr = {byte_v, r_addr[7:0]};
                                n_hidx = r_hidx + 2'd1;
                            end
                            ihrl_pkg::HB_ADDR_L: begin
                                n_addr = {r_addr[15:8], byte_v};
                                n_hidx = r_hidx + 2'd1;
                            end
                            default: begin
                                if (byte_v == ihrl_pkg::REC_DATA) begin
                                    if (r_len > MAX_B) begin
                                        o_push     = 1'b1;
                                        o_cmd.kind = ihrl_pkg::KIND_LEN_ERR;
                                        n_phase    = ihrl_pkg::PH_WAIT;
                                    end else begin
                                        n_cnt   = '0;
                                        n_phase = (r_len == '0) ? ihrl_pkg::PH_CSUM
                                                                : ihrl_pkg::PH_DATA;
                                    end
                                end else if (byte_v == ihrl_pkg::REC_EOF) begin
                                    o_push     = 1'b1;
                                    o_cmd.kind = ihrl_pkg::KIND_EOF;
                                    n_phase    = ihrl_pkg::PH_WAIT;
                                end else begin
                                    o_push     = 1'b1;
                                    o_cmd.kind = ihrl_pkg::KIND_TYPE_ERR;
                                    n_phase    = ihrl_pkg::PH_WAIT;
                                end
                            end
                        endcase
                    end
                    ihrl_pkg::PH_DATA: begin
                        o_buf_wr.we = (r_cnt < MAX_B);
                        n_cnt       = cnt_inc;
                        if (cnt_inc >= r_len || cnt_inc >= MAX_B) begin
                            n_phase = ihrl_pkg::PH_CSUM;
                        end
                    end
                    default: begin
                        n_phase = ihrl_pkg::PH_WAIT;
                        if (sum_v != '0) begin
                            o_push     = 1'b1;
                            o_cmd.kind = ihrl_pkg::KIND_CSUM_ERR;
                        end else if (r_len != '0) begin
                            o_push     = 1'b1;
                            o_cmd.kind = ihrl_pkg::KIND_WRITE;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ihrl_pkg::PH_WAIT;
            r_hi    <= '0;
            r_have  <= 1'b0;
            r_hidx  <= '0;
            r_len   <= '0;
            r_addr  <= '0;
            r_cnt   <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_hi    <= n_hi;
            r_have  <= n_have;
            r_hidx  <= n_hidx;
            r_len   <= n_len;
            r_addr  <= n_addr;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
        end
    end

endmodule

[design/ihrl_queue.sv]
// Two-entry job queue between parser and emitter.
module ihrl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ihrl_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output ihrl_pkg::t_cmd o_head,
    output logic           o_empty,
    output logic           o_full
);

    ihrl_pkg::t_cmd r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           do_push, do_pop;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

[design/ihrl_back.sv]
// Emitter: holds the record buffer and plays queued jobs out as result beats.
module ihrl_back #(
    parameter int MAX_RECORD_BYTES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ihrl_pkg::t_buf_wr           i_buf_wr,
    input  ihrl_pkg::t_cmd              i_head,
    input  logic                        i_q_empty,
    output logic                        o_pop,
    output logic                        o_busy,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ihrl_pkg::KIND_W-1:0] o_kind,
    output logic [ihrl_pkg::ADDR_W-1:0] o_write_address,
    output logic [ihrl_pkg::BYTE_W-1:0] o_write_data,
    output logic                        o_last
);

    localparam int IDX_W = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;

    logic [ihrl_pkg::BYTE_W-1:0] r_buf [MAX_RECORD_BYTES];

    // burst sequencer
    logic                        r_busy;
    logic [ihrl_pkg::BYTE_W-1:0] r_k, r_len;
    logic [ihrl_pkg::ADDR_W-1:0] r_base;

    // read stage
    logic                        r_s1v;
    ihrl_pkg::t_kind             r_s1kind;
    logic [ihrl_pkg::ADDR_W-1:0] r_s1addr;
    logic                        r_s1last;
    logic [ihrl_pkg::BYTE_W-1:0] r_s1data;

    // output register
    logic                        r_ov;
    ihrl_pkg::t_kind             r_okind;
    logic [ihrl_pkg::ADDR_W-1:0] r_oaddr;
    logic [ihrl_pkg::BYTE_W-1:0] r_odata;
    logic                        r_olast;

    logic out_free, s1_free, issue_burst, issue_single, start, burst_last;

    assign out_free     = !r_ov || !i_out_stall;
    assign s1_free      = !r_s1v || out_free;
    assign issue_burst  = r_busy && s1_free;
    assign issue_single = !r_busy && !i_q_empty && s1_free &&
                          (i_head.kind != ihrl_pkg::KIND_WRITE);
    assign start        = !r_busy && !i_q_empty && (i_head.kind == ihrl_pkg::KIND_WRITE);
    assign burst_last   = (r_k == r_len - 8'd1);
    assign o_pop        = issue_single || start;
    assign o_busy       = r_busy;

    always_ff @(posedge i_clk) begin
        if (i_buf_wr.we) begin
            r_buf[i_buf_wr.idx[IDX_W-1:0]] <= i_buf_wr.data;
        end
        if (issue_burst) begin
            r_s1data <= r_buf[r_k[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_base <= i_head.addr;
            r_len  <= i_head.len;
        end
        if (s1_free) begin
            if (issue_burst) begin
                r_s1kind <= ihrl_pkg::KIND_WRITE;
                r_s1addr <= r_base + ihrl_pkg::ADDR_W'(r_k);
                r_s1last <= burst_last;
            end else begin
                r_s1kind <= i_head.kind;
                r_s1addr <= '0;
                r_s1last <= 1'b1;
            end
        end
        if (out_free) begin
            r_okind <= r_s1kind;
            r_oaddr <= r_s1addr;
            r_odata <= (r_s1kind == ihrl_pkg::KIND_WRITE) ? r_s1data : '0;
            r_olast <= r_s1last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
            r_s1v  <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (issue_burst) begin
                r_k <= r_k + 8'd1;
                if (burst_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (s1_free) begin
                r_s1v <= issue_burst || issue_single;
            end
            if (out_free) begin
                r_ov <= r_s1v;
            end
        end
    end

    assign o_out_valid     = r_ov;
    assign o_kind          = r_okind;
    assign o_write_address = r_oaddr;
    assign o_write_data    = r_odata;
    assign o_last          = r_olast;

endmodule

[design/ihrl_checker.sv]
// Port-level checks for the Intel HEX record loader, bound to the top level.
module ihrl_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [ihrl_pkg::KIND_W-1:0] o_kind,
    input logic [ihrl_pkg::ADDR_W-1:0] o_write_address,
    input logic [ihrl_pkg::BYTE_W-1:0] o_write_data,
    input logic                        o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_kind) && $stable(o_write_address) &&
            $stable(o_write_data) && $stable(o_last))
        else $error("stalled result beat changed");

    a_single_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != ihrl_pkg::KIND_WRITE |->
            o_last && o_write_address == '0 && o_write_data == '0)
        else $error("status result not a lone zeroed beat");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_kind <= ihrl_pkg::KIND_TYPE_ERR)
        else $error("result kind out of range");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

endmodule

bind intel_hex_record_loader ihrl_checker u_ihrl_checker (.*);

[tb/tb_intel_hex_record_loader.sv]
// Self-checking testbench for the Intel HEX record loader: character stream in, results out.
module tb_intel_hex_record_loader;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BYTES  = 32;
    localparam int STIM_CHARS = 460;
    localparam int CYCLE_CAP  = 200000;
    localparam int HOLD_LEN   = 250;
    localparam int DRAIN_WAIT = 60;

    typedef struct packed {
        ihrl_pkg::t_kind kind;
        logic [15:0]     addr;
        logic [7:0]      data;
        logic            last;
    } t_hex_result;

    typedef struct {
        logic [7:0] ch;
        bit         sync;   // hold this char until every result is back
    } t_hex_char;

    logic                          i_clk;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    logic [ihrl_pkg::BYTE_W-1:0]   i_char_in   = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [ihrl_pkg::KIND_W-1:0]   o_kind;
    logic [ihrl_pkg::ADDR_W-1:0]   o_write_address;
    logic [ihrl_pkg::BYTE_W-1:0]   o_write_data;
    logic                          o_last;

    t_hex_char   char_q[$];
    t_hex_result due_results[$];

    int n_accepted = 0;
    int n_cycles   = 0;
    int n_fail     = 0;
    int n_writes   = 0;
    int n_eof      = 0;
    int n_errs     = 0;
    int hold_left  = 0;
    bit hold_done  = 0;

    // parser state of the loader
    ihrl_pkg::t_phase    hex_phase = ihrl_pkg::PH_WAIT;
    logic [3:0]          hi_nib    = '0;
    logic                have_hi   = 1'b0;
    ihrl_pkg::t_hdr_byte hdr_idx   = ihrl_pkg::HB_LENGTH;
    logic [7:0]          rec_len   = '0;
    logic [15:0]         rec_addr  = '0;
    logic [7:0]          data_cnt  = '0;
    logic [7:0]          rec_sum   = '0;
    logic [7:0]          rec_buf [MAX_BYTES];

    intel_hex_record_loader #(
        .MAX_RECORD_BYTES(MAX_BYTES)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_char_in       (i_char_in),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_write_address (o_write_address),
        .o_write_data    (o_write_data),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [3:0] char_nibble(input logic [7:0] c);
        if (c >= ihrl_pkg::CH_ZERO && c <= ihrl_pkg::CH_NINE)
            return 4'(c - ihrl_pkg::CH_ZERO);
        if (c >= ihrl_pkg::CH_UA && c <= ihrl_pkg::CH_UF)
            return 4'(c - ihrl_pkg::CH_UA + ihrl_pkg::HEX_TEN);
        return 4'(c - ihrl_pkg::CH_LA + ihrl_pkg::HEX_TEN);
    endfunction

    task automatic emit_single(input ihrl_pkg::t_kind kind);
        due_results.push_back('{kind: kind, addr: '0, data: '0, last: 1'b1});
        hex_phase = ihrl_pkg::PH_WAIT;
    endtask

    task automatic parse_hex_char(input logic [7:0] c);
        logic [3:0] nib;
        logic [7:0] b;
        int         n;
        if (hex_phase == ihrl_pkg::PH_WAIT) begin
            if (c == ihrl_pkg::CH_COLON) begin
                hex_phase = ihrl_pkg::PH_HEADER;
                have_hi   = 1'b0;
                hi_nib    = '0;
                hdr_idx   = ihrl_pkg::HB_LENGTH;
                data_cnt  = '0;
                rec_sum   = '0;
            end
            return;
        end
        nib = char_nibble(c);
        if (!have_hi) begin
            hi_nib  = nib;
            have_hi = 1'b1;
            return;
        end
        have_hi = 1'b0;
        b       = {hi_nib, nib};
        rec_sum = rec_sum + b;
        case (hex_phase)
            ihrl_pkg::PH_HEADER: begin
                case (hdr_idx)
                    ihrl_pkg::HB_LENGTH: rec_len = b;
                    ihrl_pkg::HB_ADDR_H: rec_addr[15:8] = b;
                    ihrl_pkg::HB_ADDR_L: rec_addr[7:0] = b;
                    default: begin
                        if (b == ihrl_pkg::REC_DATA) begin
                            if (rec_len > MAX_BYTES) begin
                                emit_single(ihrl_pkg::KIND_LEN_ERR);
                            end else begin
                                data_cnt  = '0;
                                hex_phase = (rec_len == 0) ? ihrl_pkg::PH_CSUM
                                                           : ihrl_pkg::PH_DATA;
                            end
                        end else if (b == ihrl_pkg::REC_EOF) begin
                            emit_single(ihrl_pkg::KIND_EOF);
                        end else begin
                            emit_single(ihrl_pkg::KIND_TYPE_ERR);
                        end
                    end
                endcase
                hdr_idx = ihrl_pkg::t_hdr_byte'(hdr_idx + 2'd1);
            end
            ihrl_pkg::PH_DATA: begin
                if (data_cnt < MAX_BYTES)
                    rec_buf[data_cnt[4:0]] = b;
                data_cnt = data_cnt + 8'd1;
                if (data_cnt >= rec_len || data_cnt >= MAX_BYTES)
                    hex_phase = ihrl_pkg::PH_CSUM;
            end
            default: begin
                hex_phase = ihrl_pkg::PH_WAIT;
                if (rec_sum != 0) begin
                    emit_single(ihrl_pkg::KIND_CSUM_ERR);
                end else begin
                    n = (rec_len > MAX_BYTES) ? MAX_BYTES : int'(rec_len);
                    for (int k = 0; k < n; k++)
                        due_results.push_back('{kind: ihrl_pkg::KIND_WRITE,
                                                addr: 16'(rec_addr + k),
                                                data: rec_buf[k],
                                                last: (k == n - 1)});
                end
            end
        endcase
    endtask

    // any char that folds to the nibble: digit, upper, lower or stray char
    function automatic logic [7:0] nib_char(input logic [3:0] nib);
        int         pick;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (nib < 10) begin
            if (pick < 85)
                return ihrl_pkg::CH_ZERO + nib;
        end else if (pick < 55) begin
            return ihrl_pkg::CH_UA + nib - ihrl_pkg::HEX_TEN;
        end else if (pick < 85) begin
            return ihrl_pkg::CH_LA + nib - ihrl_pkg::HEX_TEN;
        end
        do begin
            c = {4'($urandom_range(0, 15)), 4'(nib + 4'd7)};
        end while ((c >= ihrl_pkg::CH_ZERO && c <= ihrl_pkg::CH_NINE)
                   || (c >= ihrl_pkg::CH_UA && c <= ihrl_pkg::CH_UF)
                   || c == ihrl_pkg::CH_COLON);
        return c;
    endfunction

    task automatic put_char(input logic [7:0] c, input bit sync);
        char_q.push_back('{ch: c, sync: sync});
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i], 1'b0);
    endtask

    task automatic add_byte(input logic [7:0] b);
        put_char(nib_char(b[7:4]), 1'b0);
        put_char(nib_char(b[3:0]), 1'b0);
    endtask

    task automatic add_record(input logic [7:0] len, input logic [15:0] addr,
                              input logic [7:0] rtype, input logic [7:0] sum_skew,
                              input bit sync);
        logic [7:0] sum;
        logic [7:0] b;
        int         nbytes;
        put_char(ihrl_pkg::CH_COLON, sync);
        sum = len + addr[15:8] + addr[7:0] + rtype;
        add_byte(len);
        add_byte(addr[15:8]);
        add_byte(addr[7:0]);
        add_byte(rtype);
        nbytes = (len > MAX_BYTES) ? 4 : int'(len);
        for (int k = 0; k < nbytes; k++) begin
            b   = 8'($urandom_range(0, 255));
            sum = sum + b;
            add_byte(b);
        end
        add_byte(8'(8'd0 - sum) + sum_skew);
    endtask

    function automatic bit roll_idle();
        if (n_accepted >= 300 && n_accepted < 380)
            return 1'b0;
        return $urandom_range(0, 99) < 17;
    endfunction

    // driver
    always @(posedge i_clk) begin : driver
        logic fire;
        fire = i_in_valid && !o_in_stall;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (fire) begin
                parse_hex_char(i_char_in);
                void'(char_q.pop_front());
                n_accepted++;
            end
            if (fire || !i_in_valid) begin
                if (char_q.size() != 0 && !(char_q[0].sync && due_results.size() != 0)
                    && !roll_idle()) begin
                    i_in_valid <= 1'b1;
                    i_char_in  <= char_q[0].ch;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output back-pressure, with one long hold-off
    always @(posedge i_clk) begin : rx_stall
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (hold_left != 0) begin
                hold_left--;
            end else if (!hold_done && n_accepted >= 150) begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            i_out_stall <= (hold_left != 0) || roll_idle();
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        t_hex_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                $error("unexpected result: kind %0d addr %h data %h last %0d",
                       o_kind, o_write_address, o_write_data, o_last);
                n_fail++;
            end else begin
                want = due_results.pop_front();
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_kind);
                    n_fail++;
                end
                if (o_write_address !== want.addr) begin
                    $error("write_address: expected %h, got %h", want.addr, o_write_address);
                    n_fail++;
                end
                if (o_write_data !== want.data) begin
                    $error("write_data: expected %h, got %h", want.data, o_write_data);
                    n_fail++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    n_fail++;
                end
                case (want.kind)
                    ihrl_pkg::KIND_WRITE: n_writes++;
                    ihrl_pkg::KIND_EOF:   n_eof++;
                    default:              n_errs++;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        n_cycles++;
        if (n_cycles > CYCLE_CAP) begin
            $error("timeout: %0d chars left, %0d results due", char_q.size(),
                   due_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int         pick;
        bit         sync;
        bit         mid_sync_done;
        logic [7:0] c;
        mid_sync_done = 1'b0;

        // directed
        put_char(8'h00, 1'b0);
        put_char(8'hFF, 1'b0);
        put_char(8'h80, 1'b0);
        put_text(":00000001FF");
        put_text(":02abcd00deadfb");
        put_text(":01123400:C7D");
        add_record(8'd2, 16'hFFFF, ihrl_pkg::REC_DATA, 8'd0, 1'b0);
        add_record(8'd32, 16'hFFF0, ihrl_pkg::REC_DATA, 8'd0, 1'b0);
        add_record(8'd0, 16'h0000, ihrl_pkg::REC_DATA, 8'd0, 1'b0);
        add_record(8'd33, 16'h1000, ihrl_pkg::REC_DATA, 8'd0, 1'b0);
        add_record(8'd255, 16'h2000, ihrl_pkg::REC_DATA, 8'd0, 1'b0);
        add_record(8'd1, 16'h3000, 8'h02, 8'd0, 1'b0);
        add_record(8'd0, 16'h4000, 8'hFF, 8'd0, 1'b0);
        add_record(8'd4, 16'h5000, ihrl_pkg::REC_DATA, 8'h01, 1'b0);
        put_char(8'h0D, 1'b1);

        // random
        while (char_q.size() < STIM_CHARS) begin
            pick = $urandom_range(0, 99);
            sync = !mid_sync_done && char_q.size() > 300;
            if (sync) begin
                mid_sync_done = 1'b1;
                put_char(8'h0D, 1'b1);
            end
            if (pick < 68)
                add_record(8'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 32)
                                                          : $urandom_range(0, 8)),
                           16'($urandom_range(0, 65535)), ihrl_pkg::REC_DATA,
                           8'd0, 1'b0);
            else if (pick < 76)
                add_record(8'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                           ihrl_pkg::REC_EOF, 8'd0, 1'b0);
            else if (pick < 82)
                add_record(8'($urandom_range(0, 8)), 16'($urandom_range(0, 65535)),
                           ihrl_pkg::REC_DATA, 8'($urandom_range(1, 255)), 1'b0);
            else if (pick < 86)
                add_record(8'($urandom_range(33, 255)), 16'($urandom_range(0, 65535)),
                           ihrl_pkg::REC_DATA, 8'd0, 1'b0);
            else if (pick < 90)
                add_record(8'($urandom_range(0, 4)), 16'($urandom_range(0, 65535)),
                           8'($urandom_range(2, 255)), 8'd0, 1'b0);
            else if (pick < 95)
                repeat ($urandom_range(1, 4)) begin
                    do c = 8'($urandom_range(0, 255)); while (c == ihrl_pkg::CH_COLON);
                    put_char(c, 1'b0);
                end
            else begin
                // truncated record: a colon and a few arbitrary chars
                put_char(ihrl_pkg::CH_COLON, 1'b0);
                repeat ($urandom_range(1, 7))
                    put_char(8'($urandom_range(0, 255)), 1'b0);
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (char_q.size() != 0)
            @(posedge i_clk);
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d chars; checked %0d writes, %0d end-of-file, %0d error results.",
                 n_accepted, n_writes, n_eof, n_errs);
        $display("Long output hold-off and a drained pause were both exercised.");
        if (n_fail == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
